// ----- src/staging_buffer_pool_allocator_assert.svh -----
// assertion macros shared by the buffer pool allocator modules
// expects aclk and aresetn in the scope of the including module
`ifndef STAGING_BUFFER_POOL_ALLOCATOR_ASSERT_SVH
`define STAGING_BUFFER_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SBPA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbpa assertion failed");

// next-cycle implication
`define SBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbpa assertion failed");

`endif

// ----- src/sbpa_pkg.sv -----
// shared types, widths and codes for the buffer pool allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbpa_pkg;

    localparam int SLOTS_DEF         = 16;
    localparam int MIN_SIZE_LOG2_DEF = 16;
    localparam int MAX_SIZE_LOG2_DEF = 40;

    localparam int CMD_W      = 2;
    localparam int REQ_W      = 41;
    localparam int IDX_IN_W   = 4;
    localparam int KEEP_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int TOTAL_W    = 45;
    localparam int LOG2_W     = 6;
    localparam int BATCH_W    = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_PACK_W   = REQ_W + IDX_IN_W + KEEP_W;
    localparam int IN_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;
    localparam int OUT_PACK_W  = SLOT_OUT_W + REQ_W + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [BATCH_W-1:0] BATCH_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETIRE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FIT    = 3'd0,
        ST_REGROW = 3'd1,
        ST_NEW    = 3'd2,
        ST_ZERO   = 3'd3,
        ST_FAIL   = 3'd4,
        ST_DONE   = 3'd5
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [REQ_W-1:0]    req;
        logic [IDX_IN_W-1:0] idx;
        logic [KEEP_W-1:0]   keep;
        logic                class_ok;
        logic [LOG2_W-1:0]   size_log2;
    } entry_t;

endpackage

`default_nettype wire

// ----- src/sbpa_front.sv -----
// front end: takes input words and works out the size class of acquires
// depends on sbpa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "staging_buffer_pool_allocator_assert.svh"

module sbpa_front #(
    parameter int MIN_SIZE_LOG2 = sbpa_pkg::MIN_SIZE_LOG2_DEF,
    parameter int MAX_SIZE_LOG2 = sbpa_pkg::MAX_SIZE_LOG2_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sbpa_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [sbpa_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  push,
    output sbpa_pkg::entry_t                      push_entry,
    input  wire logic                             q_full
);

    localparam int CAP_W = MAX_SIZE_LOG2 + 1;
    localparam int CMP_W = (CAP_W > sbpa_pkg::REQ_W) ? CAP_W : sbpa_pkg::REQ_W;

    typedef enum logic [1:0] {F_IDLE, F_CLASS, F_PUSH} fstate_t;

    fstate_t          state_reg;
    sbpa_pkg::entry_t entry_reg;

    logic [sbpa_pkg::REQ_W-1:0] in_req;
    logic [CMP_W-1:0]           pow;
    logic                       fits;

    assign in_req = s_tdata[sbpa_pkg::REQ_W-1:0];
    assign pow    = CMP_W'(1) << entry_reg.size_log2;
    assign fits   = pow >= CMP_W'(entry_reg.req);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_tvalid) begin
                        entry_reg.cmd       <= s_tuser;
                        entry_reg.req       <= in_req;
                        entry_reg.idx       <= s_tdata[sbpa_pkg::REQ_W +: sbpa_pkg::IDX_IN_W];
                        entry_reg.keep      <= s_tdata[sbpa_pkg::REQ_W + sbpa_pkg::IDX_IN_W +:
                                                       sbpa_pkg::KEEP_W];
                        entry_reg.class_ok  <= 1'b0;
                        entry_reg.size_log2 <= sbpa_pkg::LOG2_W'(MIN_SIZE_LOG2);
                        if (s_tuser == sbpa_pkg::CMD_ACQUIRE && in_req != '0) begin
                            state_reg <= F_CLASS;
                        end else begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_CLASS: begin
                    if (fits) begin
                        entry_reg.class_ok <= 1'b1;
                        state_reg          <= F_PUSH;
                    end else if (entry_reg.size_log2 == sbpa_pkg::LOG2_W'(MAX_SIZE_LOG2)) begin
                        state_reg <= F_PUSH;
                    end else begin
                        entry_reg.size_log2 <= entry_reg.size_log2 + 1'b1;
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == F_IDLE);
    assign push       = (state_reg == F_PUSH) && !q_full;
    assign push_entry = entry_reg;

    `SBPA_ASSERT(a_class_range, push && push_entry.class_ok, push_entry.size_log2 >= sbpa_pkg::LOG2_W'(MIN_SIZE_LOG2) && push_entry.size_log2 <= sbpa_pkg::LOG2_W'(MAX_SIZE_LOG2))
    `SBPA_ASSERT(a_zero_unclassed, push && push_entry.req == '0, !push_entry.class_ok)

endmodule

`default_nettype wire

// ----- src/sbpa_queue.sv -----
// short fifo of classified words between front and back end
// depends on sbpa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "staging_buffer_pool_allocator_assert.svh"

module sbpa_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sbpa_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output sbpa_pkg::entry_t       pop_entry,
    output logic                   empty
);

    localparam int DEPTH = sbpa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    sbpa_pkg::entry_t   store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = store_reg[rd_ptr_reg];

    `SBPA_ASSERT(a_no_overflow, push && !pop, count_reg < CNT_W'(DEPTH))
    `SBPA_ASSERT(a_no_underflow, pop, count_reg != '0)

endmodule

`default_nettype wire

// ----- src/sbpa_back.sv -----
// back end: slot table, best-fit search, release scan, pool total and result register
// depends on sbpa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "staging_buffer_pool_allocator_assert.svh"

module sbpa_back #(
    parameter int SLOTS         = sbpa_pkg::SLOTS_DEF,
    parameter int MIN_SIZE_LOG2 = sbpa_pkg::MIN_SIZE_LOG2_DEF,
    parameter int MAX_SIZE_LOG2 = sbpa_pkg::MAX_SIZE_LOG2_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_empty,
    output logic                                   pop,
    input  wire sbpa_pkg::entry_t                  head,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sbpa_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic [sbpa_pkg::STATUS_W-1:0]          m_tuser
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAP_W = MAX_SIZE_LOG2 + 1;
    localparam int SUM_W = ((CAP_W > sbpa_pkg::TOTAL_W) ? CAP_W : sbpa_pkg::TOTAL_W) + 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {B_IDLE, B_SCAN, B_DECIDE, B_TOTAL, B_OUT} bstate_t;

    bstate_t state_reg;
    sbpa_pkg::entry_t item_reg;

    logic [SLOTS-1:0]               present_reg;
    logic [SLOTS-1:0]               busy_reg;
    logic [sbpa_pkg::LOG2_W-1:0]    size_mem [SLOTS];
    logic [sbpa_pkg::BATCH_W-1:0]   rel_mem  [SLOTS];
    logic [sbpa_pkg::LOG2_W-1:0]    size_rd_reg;
    logic [sbpa_pkg::BATCH_W-1:0]   rel_rd_reg;

    logic [IDX_W-1:0]               scan_idx_reg;
    logic                           issue_reg;
    logic                           proc_vld_reg;
    logic [IDX_W-1:0]               proc_idx_reg;

    logic                           fit_found_reg;
    logic [IDX_W-1:0]               fit_idx_reg;
    logic [sbpa_pkg::LOG2_W-1:0]    fit_log2_reg;
    logic                           big_found_reg;
    logic [IDX_W-1:0]               big_idx_reg;
    logic [sbpa_pkg::LOG2_W-1:0]    big_log2_reg;
    logic                           abs_found_reg;
    logic [IDX_W-1:0]               abs_idx_reg;

    logic [sbpa_pkg::TOTAL_W-1:0]   acc_reg;
    logic [sbpa_pkg::BATCH_W-1:0]   batch_reg;
    logic [sbpa_pkg::KEEP_W-1:0]    hold_reg;

    sbpa_pkg::status_t              res_status_reg;
    logic                           res_grant_reg;
    logic [IDX_W-1:0]               res_slot_reg;
    logic [sbpa_pkg::LOG2_W-1:0]    res_log2_reg;

    logic                           m_tvalid_reg;
    logic [sbpa_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [sbpa_pkg::STATUS_W-1:0]  m_tuser_reg;

    // head decode
    logic                           idx_ok;
    logic [IDX_W-1:0]               idx_sel;
    logic                           retire_ok;
    logic [sbpa_pkg::BATCH_W:0]     due_sum;
    logic [sbpa_pkg::BATCH_W-1:0]   due;

    // per-slot processing
    logic                           cur_present;
    logic                           cur_free;
    logic                           fit_take;
    logic                           big_take;
    logic                           abs_take;
    logic                           free_now;
    logic [CAP_W-1:0]               cur_cap;
    logic [SUM_W-1:0]               sum;
    logic                           pass_done;
    logic                           out_free;

    // decide
    logic                           dec_regrow;
    logic                           dec_new;

    // memory write ports
    logic                           size_we;
    logic [IDX_W-1:0]               size_waddr;
    logic                           rel_we;
    logic [IDX_W-1:0]               rel_waddr;
    logic [sbpa_pkg::BATCH_W-1:0]   rel_wdata;

    logic [sbpa_pkg::SLOT_OUT_W-1:0] out_slot;
    logic [sbpa_pkg::REQ_W-1:0]      out_bytes;

    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign idx_ok   = int'(head.idx) < SLOTS;
    assign idx_sel  = IDX_W'(head.idx);
    assign retire_ok = idx_ok && present_reg[idx_sel];
    assign due_sum  = {1'b0, batch_reg} + (sbpa_pkg::BATCH_W + 1)'(hold_reg);
    assign due      = due_sum[sbpa_pkg::BATCH_W] ? sbpa_pkg::BATCH_MAX
                                                 : due_sum[sbpa_pkg::BATCH_W-1:0];

    assign cur_present = present_reg[proc_idx_reg];
    assign cur_free    = cur_present && !busy_reg[proc_idx_reg];
    assign fit_take    = proc_vld_reg && cur_free && item_reg.class_ok &&
                         size_rd_reg >= item_reg.size_log2 &&
                         (!fit_found_reg || size_rd_reg < fit_log2_reg);
    assign big_take    = proc_vld_reg && cur_free &&
                         (!big_found_reg || size_rd_reg > big_log2_reg);
    assign abs_take    = proc_vld_reg && !cur_present && !abs_found_reg;
    assign free_now    = proc_vld_reg && item_reg.cmd == sbpa_pkg::CMD_COLLECT &&
                         cur_present && busy_reg[proc_idx_reg] && rel_rd_reg != '0 &&
                         batch_reg >= rel_rd_reg;
    assign cur_cap     = cur_present ? (CAP_W'(1) << size_rd_reg) : '0;
    assign sum         = SUM_W'(acc_reg) + SUM_W'(cur_cap);
    assign pass_done   = proc_vld_reg && proc_idx_reg == LAST;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign dec_regrow  = !fit_found_reg && item_reg.class_ok && big_found_reg;
    assign dec_new     = !fit_found_reg && item_reg.class_ok && !big_found_reg &&
                         abs_found_reg;

    always_comb begin
        size_we    = (state_reg == B_DECIDE) && (dec_regrow || dec_new);
        size_waddr = dec_regrow ? big_idx_reg : abs_idx_reg;
        rel_we     = 1'b0;
        rel_waddr  = idx_sel;
        rel_wdata  = '0;
        unique case (state_reg)
            B_IDLE: begin
                rel_we    = pop && head.cmd == sbpa_pkg::CMD_RETIRE && retire_ok;
                rel_waddr = idx_sel;
                rel_wdata = due;
            end
            B_DECIDE: begin
                rel_we    = dec_new;
                rel_waddr = abs_idx_reg;
            end
            B_TOTAL: begin
                rel_we    = free_now;
                rel_waddr = proc_idx_reg;
            end
            default: begin
                rel_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_waddr] <= item_reg.size_log2;
        end
        if (rel_we) begin
            rel_mem[rel_waddr] <= rel_wdata;
        end
        size_rd_reg <= size_mem[scan_idx_reg];
        rel_rd_reg  <= rel_mem[scan_idx_reg];
    end

    assign out_slot  = res_grant_reg ? sbpa_pkg::SLOT_OUT_W'(res_slot_reg) : '0;
    assign out_bytes = res_grant_reg ? sbpa_pkg::REQ_W'(CAP_W'(1) << res_log2_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            present_reg   <= '0;
            busy_reg      <= '0;
            batch_reg     <= '0;
            hold_reg      <= sbpa_pkg::KEEP_W'(1);
            issue_reg     <= 1'b0;
            proc_vld_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != B_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            // slot pass sequencing
            proc_vld_reg <= issue_reg;
            proc_idx_reg <= scan_idx_reg;
            if (issue_reg) begin
                if (scan_idx_reg == LAST) begin
                    issue_reg <= 1'b0;
                end else begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end

            unique case (state_reg)
                B_IDLE: begin
                    if (pop) begin
                        item_reg      <= head;
                        res_grant_reg <= 1'b0;
                        scan_idx_reg  <= '0;
                        issue_reg     <= 1'b1;
                        acc_reg       <= '0;
                        fit_found_reg <= 1'b0;
                        big_found_reg <= 1'b0;
                        abs_found_reg <= 1'b0;
                        state_reg     <= (head.cmd == sbpa_pkg::CMD_ACQUIRE && head.req != '0)
                                         ? B_SCAN : B_TOTAL;
                        case (head.cmd)
                            sbpa_pkg::CMD_ACQUIRE: begin
                                if (head.req == '0) begin
                                    res_status_reg <= sbpa_pkg::ST_ZERO;
                                end
                            end
                            sbpa_pkg::CMD_RETIRE: begin
                                res_status_reg <= retire_ok ? sbpa_pkg::ST_DONE
                                                            : sbpa_pkg::ST_FAIL;
                            end
                            sbpa_pkg::CMD_COLLECT: begin
                                res_status_reg <= sbpa_pkg::ST_DONE;
                                hold_reg <= (head.keep == '0) ? sbpa_pkg::KEEP_W'(1)
                                                              : head.keep;
                                if (batch_reg != sbpa_pkg::BATCH_MAX) begin
                                    batch_reg <= batch_reg + 1'b1;
                                end
                            end
                            default: begin
                                res_status_reg <= sbpa_pkg::ST_FAIL;
                            end
                        endcase
                    end
                end
                B_SCAN: begin
                    if (fit_take) begin
                        fit_found_reg <= 1'b1;
                        fit_idx_reg   <= proc_idx_reg;
                        fit_log2_reg  <= size_rd_reg;
                    end
                    if (big_take) begin
                        big_found_reg <= 1'b1;
                        big_idx_reg   <= proc_idx_reg;
                        big_log2_reg  <= size_rd_reg;
                    end
                    if (abs_take) begin
                        abs_found_reg <= 1'b1;
                        abs_idx_reg   <= proc_idx_reg;
                    end
                    if (pass_done) begin
                        state_reg <= B_DECIDE;
                    end
                end
                B_DECIDE: begin
                    if (fit_found_reg) begin
                        res_grant_reg          <= 1'b1;
                        res_status_reg         <= sbpa_pkg::ST_FIT;
                        res_slot_reg           <= fit_idx_reg;
                        res_log2_reg           <= fit_log2_reg;
                        busy_reg[fit_idx_reg]  <= 1'b1;
                    end else if (dec_regrow) begin
                        res_grant_reg          <= 1'b1;
                        res_status_reg         <= sbpa_pkg::ST_REGROW;
                        res_slot_reg           <= big_idx_reg;
                        res_log2_reg           <= item_reg.size_log2;
                        busy_reg[big_idx_reg]  <= 1'b1;
                    end else if (dec_new) begin
                        res_grant_reg            <= 1'b1;
                        res_status_reg           <= sbpa_pkg::ST_NEW;
                        res_slot_reg             <= abs_idx_reg;
                        res_log2_reg             <= item_reg.size_log2;
                        busy_reg[abs_idx_reg]    <= 1'b1;
                        present_reg[abs_idx_reg] <= 1'b1;
                    end else begin
                        res_status_reg <= sbpa_pkg::ST_FAIL;
                        res_grant_reg  <= 1'b0;
                    end
                    scan_idx_reg <= '0;
                    issue_reg    <= 1'b1;
                    state_reg    <= B_TOTAL;
                end
                B_TOTAL: begin
                    if (proc_vld_reg) begin
                        acc_reg <= (sum > SUM_W'(sbpa_pkg::TOTAL_MAX))
                                   ? sbpa_pkg::TOTAL_MAX : sbpa_pkg::TOTAL_W'(sum);
                    end
                    if (free_now) begin
                        busy_reg[proc_idx_reg] <= 1'b0;
                    end
                    if (pass_done) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= sbpa_pkg::OUT_TDATA_W'({acc_reg, out_bytes, out_slot});
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SBPA_ASSERT_NEXT(a_present_sticky, 1'b1, (present_reg & $past(present_reg)) == $past(present_reg))
    `SBPA_ASSERT_NEXT(a_batch_monotonic, 1'b1, batch_reg >= $past(batch_reg))
    `SBPA_ASSERT(a_grant_held, state_reg == B_OUT && res_grant_reg, present_reg[res_slot_reg] && busy_reg[res_slot_reg])

endmodule

`default_nettype wire

// ----- src/staging_buffer_pool_allocator.sv -----
// acquire of a nonzero size steps through the size classes in the front end, then the
// back end walks the slot table twice, best-fit scan then total pass; other words take
// only the total pass; the back end walks the slot table one slot per cycle, and the
// front end overlaps with it, classifying the next word while the back end is busy
// reset: synchronous active-low aresetn empties the pool, batch counter 0, hold count 1
`timescale 1ns / 1ps
`default_nettype none

module staging_buffer_pool_allocator #(
    parameter int SLOTS         = sbpa_pkg::SLOTS_DEF,
    parameter int MIN_SIZE_LOG2 = sbpa_pkg::MIN_SIZE_LOG2_DEF,
    parameter int MAX_SIZE_LOG2 = sbpa_pkg::MAX_SIZE_LOG2_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // request_bytes, slot_index, keep_count
    input  wire logic [sbpa_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd
    input  wire logic [sbpa_pkg::CMD_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // granted_slot, granted_bytes, total_bytes
    output logic [sbpa_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // status
    output logic [sbpa_pkg::STATUS_W-1:0]          m_tuser
);

    logic             push;
    sbpa_pkg::entry_t push_entry;
    logic             q_full;
    logic             pop;
    sbpa_pkg::entry_t head;
    logic             q_empty;

    sbpa_front #(
        .MIN_SIZE_LOG2 (MIN_SIZE_LOG2),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    sbpa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (head),
        .empty      (q_empty)
    );

    sbpa_back #(
        .SLOTS         (SLOTS),
        .MIN_SIZE_LOG2 (MIN_SIZE_LOG2),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .pop      (pop),
        .head     (head),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/staging_buffer_pool_allocator_tb.sv -----
// self-checking bench for staging_buffer_pool_allocator: directed then random words
// predicts every result from its own copy of the slot table; needs sbpa_pkg and the rtl
`timescale 1ns / 1ps

module staging_buffer_pool_allocator_tb;
    import sbpa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam int RANDOM_WORDS = 1480;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 4000;

    localparam int IDX_LSB   = REQ_W;
    localparam int KEEP_LSB  = REQ_W + IDX_IN_W;
    localparam int BYTES_LSB = SLOT_OUT_W;
    localparam int TOTAL_LSB = SLOT_OUT_W + REQ_W;

    typedef struct {
        status_t              status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [REQ_W-1:0]      bytes;
        logic [TOTAL_W-1:0]    total;
    } grant_t;

    class alloc_scoreboard;
        bit                 present    [SLOTS_DEF];
        bit                 busy       [SLOTS_DEF];
        int unsigned        size_log2  [SLOTS_DEF];
        logic [BATCH_W-1:0] release_at [SLOTS_DEF];
        logic [BATCH_W-1:0] batch;
        logic [KEEP_W-1:0]  hold;
        grant_t             pending [$];
        int                 errors;
        int                 words_in;
        int                 seen [6];

        function new();
            foreach (present[i]) begin
                present[i]    = 1'b0;
                busy[i]       = 1'b0;
                size_log2[i]  = 0;
                release_at[i] = '0;
            end
            foreach (seen[i]) seen[i] = 0;
            batch    = '0;
            hold     = 8'd1;
            errors   = 0;
            words_in = 0;
        endfunction

        function longint unsigned capacity(int i);
            return 64'd1 << size_log2[i];
        endfunction

        function status_t grant_slot(logic [REQ_W-1:0] req, output int slot);
            int best;
            int k;
            best = -1;
            slot = -1;
            if (req == '0) return ST_ZERO;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!present[i] || busy[i] || capacity(i) < req) continue;
                if (best < 0 || capacity(i) < capacity(best)) best = i;
            end
            if (best >= 0) begin
                busy[best] = 1'b1;
                slot = best;
                return ST_FIT;
            end
            k = MIN_SIZE_LOG2_DEF;
            while (k <= MAX_SIZE_LOG2_DEF && (64'd1 << k) < req) k++;
            if (k > MAX_SIZE_LOG2_DEF) return ST_FAIL;
            // regrow the largest free slot
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!present[i] || busy[i]) continue;
                if (best < 0 || capacity(i) > capacity(best)) best = i;
            end
            if (best >= 0) begin
                size_log2[best] = k;
                busy[best] = 1'b1;
                slot = best;
                return ST_REGROW;
            end
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!present[i]) begin
                    present[i]    = 1'b1;
                    busy[i]       = 1'b1;
                    size_log2[i]  = k;
                    release_at[i] = '0;
                    slot = i;
                    return ST_NEW;
                end
            end
            return ST_FAIL;
        endfunction

        function void post_request(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                                   logic [IDX_IN_W-1:0] idx, logic [KEEP_W-1:0] keep);
            grant_t            g;
            status_t           st;
            int                slot;
            longint unsigned   due;
            longint unsigned   sum;
            longint unsigned   cap;
            slot = -1;
            st   = ST_FAIL;
            words_in++;
            case (cmd)
                CMD_ACQUIRE: st = grant_slot(req, slot);
                CMD_RETIRE: begin
                    if (present[idx]) begin
                        due = longint'(batch) + longint'(hold);
                        if (due > longint'(BATCH_MAX)) due = longint'(BATCH_MAX);
                        release_at[idx] = due[BATCH_W-1:0];
                        st = ST_DONE;
                    end
                end
                CMD_COLLECT: begin
                    hold = (keep != '0) ? keep : 8'd1;
                    if (batch != BATCH_MAX) batch++;
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (present[i] && busy[i] && release_at[i] != '0 &&
                            batch >= release_at[i]) begin
                            busy[i]       = 1'b0;
                            release_at[i] = '0;
                        end
                    end
                    st = ST_DONE;
                end
                default: st = ST_FAIL;
            endcase
            g.status = st;
            g.slot   = '0;
            g.bytes  = '0;
            if (slot >= 0) begin
                cap     = capacity(slot);
                g.slot  = slot[SLOT_OUT_W-1:0];
                g.bytes = cap[REQ_W-1:0];
            end
            sum = 0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (present[i]) begin
                    sum += capacity(i);
                    if (sum > longint'(TOTAL_MAX)) sum = longint'(TOTAL_MAX);
                end
            end
            g.total = sum[TOTAL_W-1:0];
            pending.insert(pending.size(), g);
        endfunction

        function void match_result(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] slot,
                                   logic [REQ_W-1:0] bytes, logic [TOTAL_W-1:0] total);
            grant_t g;
            if (!$isunknown(st) && st <= ST_DONE) seen[st]++;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            g = pending.pop_front();
            if (st !== g.status) begin
                $error("status expected %0d actual %0d", g.status, st);
                errors++;
            end
            if (slot !== g.slot) begin
                $error("granted_slot expected %0d actual %0d", g.slot, slot);
                errors++;
            end
            if (bytes !== g.bytes) begin
                $error("granted_bytes expected %0d actual %0d", g.bytes, bytes);
                errors++;
            end
            if (total !== g.total) begin
                $error("total_bytes expected %0d actual %0d", g.total, total);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [CMD_W-1:0]        s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    alloc_scoreboard pool_sb;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    int idle_cycles = 0;

    staging_buffer_pool_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pool_sb.post_request(s_tuser, s_tdata[REQ_W-1:0],
                                 s_tdata[IDX_LSB +: IDX_IN_W], s_tdata[KEEP_LSB +: KEEP_W]);
        if (aresetn && m_tvalid && m_tready)
            pool_sb.match_result(m_tuser, m_tdata[SLOT_OUT_W-1:0],
                                 m_tdata[BYTES_LSB +: REQ_W], m_tdata[TOTAL_LSB +: TOTAL_W]);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] req,
                             input logic [IDX_IN_W-1:0] idx, input logic [KEEP_W-1:0] keep);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_TDATA_W'({keep, idx, req});
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly small sizes, some exact powers of two, a few huge or oversized
    function automatic logic [REQ_W-1:0] draw_request();
        logic [63:0] wide;
        int          pick;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return '0;
        else if (pick < 33)
            return REQ_W'(wide[15:0]) + 1'b1;
        else if (pick < 70)
            return wide[REQ_W-1:0] >> $urandom_range(18, 40);
        else if (pick < 82)
            return (REQ_W'(1) << $urandom_range(0, 40)) + REQ_W'($urandom_range(0, 2)) - 1'b1;
        else if (pick < 95)
            return wide[REQ_W-1:0] >> $urandom_range(1, 20);
        else
            return (REQ_W'(1) << 40) + REQ_W'(wide[39:0] | 40'd1);
    endfunction

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = rx_quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            if (taken % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [KEEP_W-1:0] keep;
        pool_sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(CMD_RETIRE,  '0,              4'd0,  8'd0);
        send_word(CMD_ACQUIRE, '0,              4'd0,  8'd0);
        send_word(CMD_ACQUIRE, 41'd1,           4'd0,  8'd0);
        send_word(CMD_ACQUIRE, 41'd65536,       4'd0,  8'd0);
        send_word(CMD_ACQUIRE, 41'd65537,       4'd0,  8'd0);
        send_word(CMD_ACQUIRE, 41'd1 << 40,     4'd0,  8'd0);
        send_word(CMD_ACQUIRE, (41'd1 << 40) + 41'd1, 4'd0, 8'd0);
        send_word(CMD_ACQUIRE, '1,              4'd0,  8'd0);
        send_word(CMD_UNKNOWN, '1,              4'd15, 8'd255);
        send_word(CMD_RETIRE,  '0,              4'd0,  8'd0);
        send_word(CMD_RETIRE,  '0,              4'd1,  8'd0);
        send_word(CMD_COLLECT, '0,              4'd0,  8'd0);
        // two equal free slots, lowest index wins
        send_word(CMD_ACQUIRE, 41'd100,         4'd0,  8'd0);
        send_word(CMD_RETIRE,  '0,              4'd2,  8'd0);
        send_word(CMD_COLLECT, '0,              4'd0,  8'd3);
        send_word(CMD_ACQUIRE, 41'd1 << 20,     4'd0,  8'd0);
        // retire while free, slot is busy again when due
        send_word(CMD_RETIRE,  '0,              4'd1,  8'd0);
        send_word(CMD_ACQUIRE, 41'd10,          4'd0,  8'd0);
        send_word(CMD_COLLECT, '0,              4'd0,  8'd255);
        send_word(CMD_COLLECT, '0,              4'd0,  8'd255);
        send_word(CMD_COLLECT, '0,              4'd0,  8'd255);
        send_word(CMD_RETIRE,  '0,              4'd15, 8'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 42)
                cmd = CMD_ACQUIRE;
            else if (pick < 70)
                cmd = CMD_RETIRE;
            else if (pick < 95)
                cmd = CMD_COLLECT;
            else
                cmd = CMD_UNKNOWN;
            keep = ($urandom_range(0, 9) == 0) ? KEEP_W'($urandom) : KEEP_W'($urandom_range(0, 4));
            send_word(cmd, draw_request(), IDX_IN_W'($urandom), keep);
        end
        s_tvalid <= 1'b0;

        while (pool_sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words sent; results: fit %0d, regrow %0d, new %0d, zero %0d",
                 pool_sb.words_in, pool_sb.seen[ST_FIT], pool_sb.seen[ST_REGROW],
                 pool_sb.seen[ST_NEW], pool_sb.seen[ST_ZERO]);
        $display("rejected %0d, retire/collect done %0d, field errors %0d",
                 pool_sb.seen[ST_FAIL], pool_sb.seen[ST_DONE], pool_sb.errors);
        if (pool_sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
